// File: sv/keypad_event_decode_queue_macros.svh
// assertion macros for the keypad event decode queue
`ifndef KEYPAD_EVENT_DECODE_QUEUE_MACROS_SVH
`define KEYPAD_EVENT_DECODE_QUEUE_MACROS_SVH

// same-cycle implication
`define KPD_EVQ_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KPD_EVQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/kpd_evq_pkg.sv
// shared types, constants and keymap for the keypad event decode queue
package kpd_evq_pkg;

   localparam int unsigned QUEUE_DEPTH_DEF = 16;
   localparam int unsigned KEY_W           = 8;
   localparam int unsigned CODE_W          = 8;
   localparam int unsigned REQ_W           = 2;
   localparam int unsigned NUM_W           = 6;
   localparam int unsigned ENTRY_W         = KEY_W + 1;

   // key numbers sit in the low seven bits, bit 7 marks a press
   localparam logic [CODE_W-2:0] EV_FIRST = 7'd1;
   localparam logic [CODE_W-2:0] EV_LAST  = 7'd35;

   localparam logic [KEY_W-1:0] KEY_NONE  = 8'h00;
   localparam logic [KEY_W-1:0] KEY_ALT   = 8'h01;
   localparam logic [KEY_W-1:0] KEY_SYM   = 8'h02;
   localparam logic [KEY_W-1:0] KEY_UP    = 8'h03;
   localparam logic [KEY_W-1:0] KEY_DEL   = 8'h08;
   localparam logic [KEY_W-1:0] KEY_ENT   = 8'h0D;
   localparam logic [KEY_W-1:0] KEY_SPACE = 8'h20;

   typedef enum logic [REQ_W-1:0] {
      REQ_EVENT     = 2'd0,
      REQ_POP_ANY   = 2'd1,
      REQ_POP_PRESS = 2'd2,
      REQ_RESERVED  = 2'd3
   } req_kind_type;

   // key number to character, column already mirrored
   function automatic logic [KEY_W-1:0] key_lookup(input logic [NUM_W-1:0] num);
      logic [KEY_W-1:0] ch;
      unique case (num)
         6'd0:  ch = 8'h70;
         6'd1:  ch = 8'h6F;
         6'd2:  ch = 8'h69;
         6'd3:  ch = 8'h75;
         6'd4:  ch = 8'h79;
         6'd5:  ch = 8'h74;
         6'd6:  ch = 8'h72;
         6'd7:  ch = 8'h65;
         6'd8:  ch = 8'h77;
         6'd9:  ch = 8'h71;
         6'd10: ch = KEY_DEL;
         6'd11: ch = 8'h6C;
         6'd12: ch = 8'h6B;
         6'd13: ch = 8'h6A;
         6'd14: ch = 8'h68;
         6'd15: ch = 8'h67;
         6'd16: ch = 8'h66;
         6'd17: ch = 8'h64;
         6'd18: ch = 8'h73;
         6'd19: ch = 8'h61;
         6'd20: ch = KEY_ENT;
         6'd21: ch = 8'h24;
         6'd22: ch = 8'h6D;
         6'd23: ch = 8'h6E;
         6'd24: ch = 8'h62;
         6'd25: ch = 8'h76;
         6'd26: ch = 8'h63;
         6'd27: ch = 8'h78;
         6'd28: ch = 8'h7A;
         6'd29: ch = KEY_ALT;
         6'd30: ch = KEY_UP;
         6'd31: ch = KEY_SYM;
         6'd32: ch = KEY_SPACE;
         6'd33: ch = 8'h30;
         6'd34: ch = KEY_UP;
         default: ch = KEY_NONE;
      endcase
      return ch;
   endfunction

endpackage

// File: sv/keypad_event_decode_queue.sv
// keypad event decoder with an overwrite-oldest event queue
// a raw event request is taken without leaving the idle state, so events can follow back to back
// a pop goes through the fetch and done states before the registered response valid rises (on an
// empty queue straight to done), and req_ready returns with it; in press mode each skipped release
// with more entries behind it adds a read and a fetch, and a pop waits on an unaccepted response
// reset clears the queue pointers and the response valid and sets the last key to space; the store is not cleared
module keypad_event_decode_queue #(
   parameter int unsigned QUEUE_DEPTH = kpd_evq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [kpd_evq_pkg::REQ_W-1:0]       req_type,
   input  logic [kpd_evq_pkg::CODE_W-1:0]      req_event_code,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [kpd_evq_pkg::KEY_W-1:0]       rsp_key_char,
   output logic                                rsp_pressed
);

   import kpd_evq_pkg::*;

   `include "keypad_event_decode_queue_macros.svh"

   localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_FETCH,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  rd_ff, rd_in, wr_ff, wr_in;
   logic [IDX_W-1:0]  rd_next, wr_next;
   logic              skip_ff, skip_in;
   logic              res_found_ff, res_found_in;
   logic [KEY_W-1:0]  res_key_ff, res_key_in;
   logic              res_pressed_ff, res_pressed_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [KEY_W-1:0]  rsp_key_ff, rsp_key_in;
   logic              rsp_pressed_ff, rsp_pressed_in;
   logic [KEY_W-1:0]  last_key_ff, last_key_in;
   logic              last_pressed_ff, last_pressed_in;

   logic [CODE_W-2:0] key_low;
   logic [NUM_W-1:0]  key_num;
   logic [KEY_W-1:0]  mapped;
   logic              event_ok;
   logic              fetch_hit;
   logic              ram_we;
   logic [ENTRY_W-1:0] ram_rdata;

   assign rd_next = (rd_ff == IDX_LAST) ? '0 : rd_ff + 1'b1;
   assign wr_next = (wr_ff == IDX_LAST) ? '0 : wr_ff + 1'b1;

   // key number decode
   assign key_low  = req_event_code[CODE_W-2:0];
   assign key_num  = NUM_W'(key_low - EV_FIRST);
   assign mapped   = key_lookup(key_num);
   assign event_ok = (key_low >= EV_FIRST) && (key_low <= EV_LAST) && (mapped != KEY_NONE);

   assign fetch_hit = (state_ff == S_FETCH) && (!skip_ff || ram_rdata[ENTRY_W-1]);

   kpd_evq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (wr_ff),
      .wr_data ({req_event_code[CODE_W-1], mapped}),
      .rd_addr (rd_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in        = state_ff;
      rd_in           = rd_ff;
      wr_in           = wr_ff;
      skip_in         = skip_ff;
      res_found_in    = res_found_ff;
      res_key_in      = res_key_ff;
      res_pressed_in  = res_pressed_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_key_in      = rsp_key_ff;
      rsp_pressed_in  = rsp_pressed_ff;
      last_key_in     = last_key_ff;
      last_pressed_in = last_pressed_ff;
      ram_we          = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_kind_type'(req_type))
                  REQ_EVENT: begin
                     if (event_ok) begin
                        ram_we          = 1'b1;
                        wr_in           = wr_next;
                        last_key_in     = mapped;
                        last_pressed_in = req_event_code[CODE_W-1];
                        // full ring drops its oldest entry
                        if (wr_next == rd_ff) begin
                           rd_in = rd_next;
                        end
                     end
                  end
                  REQ_POP_ANY, REQ_POP_PRESS: begin
                     skip_in = (req_kind_type'(req_type) == REQ_POP_PRESS);
                     if (rd_ff == wr_ff) begin
                        res_found_in   = 1'b0;
                        res_key_in     = KEY_NONE;
                        res_pressed_in = 1'b0;
                        state_in       = S_DONE;
                     end else begin
                        state_in = S_FETCH;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_FETCH;
         end
         S_FETCH: begin
            rd_in = rd_next;
            if (fetch_hit) begin
               res_found_in    = 1'b1;
               res_key_in      = ram_rdata[KEY_W-1:0];
               res_pressed_in  = ram_rdata[ENTRY_W-1];
               last_key_in     = ram_rdata[KEY_W-1:0];
               last_pressed_in = ram_rdata[ENTRY_W-1];
               state_in        = S_DONE;
            end else if (rd_next == wr_ff) begin
               res_found_in   = 1'b0;
               res_key_in     = KEY_NONE;
               res_pressed_in = 1'b0;
               state_in       = S_DONE;
            end else begin
               state_in = S_READ;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               rsp_found_in   = res_found_ff;
               rsp_key_in     = res_key_ff;
               rsp_pressed_in = res_pressed_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rd_ff           <= '0;
         wr_ff           <= '0;
         rsp_valid_ff    <= 1'b0;
         last_key_ff     <= KEY_SPACE;
         last_pressed_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rd_ff           <= rd_in;
         wr_ff           <= wr_in;
         rsp_valid_ff    <= rsp_valid_in;
         last_key_ff     <= last_key_in;
         last_pressed_ff <= last_pressed_in;
      end
      skip_ff        <= skip_in;
      res_found_ff   <= res_found_in;
      res_key_ff     <= res_key_in;
      res_pressed_ff <= res_pressed_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_pressed_ff <= rsp_pressed_in;
   end

   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_key_char = rsp_key_ff;
   assign rsp_pressed  = rsp_pressed_ff;

   `KPD_EVQ_ASSERT_NEXT(a_push_not_empty, clock, reset, ram_we, rd_ff != wr_ff, "queue empty after push")
   `KPD_EVQ_ASSERT_NEXT(a_last_key_pop, clock, reset, fetch_hit, (last_key_ff == res_key_ff) && (last_pressed_ff == res_pressed_ff), "last key not taken from pop")
   `KPD_EVQ_ASSERT_IMPL(a_skip_press, clock, reset, (state_ff == S_DONE) && skip_ff && res_found_ff, res_pressed_ff, "press pop returned a release")
   `KPD_EVQ_ASSERT_IMPL(a_empty_rsp, clock, reset, rsp_valid_ff && !rsp_found_ff, (rsp_key_ff == KEY_NONE) && !rsp_pressed_ff, "empty response carries data")

endmodule

// File: sv/kpd_evq_ram.sv
// generic single write port ram with registered read
module kpd_evq_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
